// ----- src/mml_music_command_parser_macros.svh -----
// Assertion helpers for the music command parser.
`ifndef MML_MUSIC_COMMAND_PARSER_MACROS_SVH
`define MML_MUSIC_COMMAND_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define MML_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define MML_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MML_ASSERT(label, prop)
`define MML_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/mml_pkg.sv -----
`default_nettype none
package mml_pkg;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_NOTE_ACC   = 3'd1;
    localparam logic [2:0] PH_NOTE_LEN   = 3'd2;
    localparam logic [2:0] PH_LEN_DIGITS = 3'd3;
    localparam logic [2:0] PH_P_START    = 3'd4;
    localparam logic [2:0] PH_NUM        = 3'd5;
    localparam logic [2:0] PH_OCT        = 3'd6;

    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_NOTE = 3'd1;
    localparam logic [2:0] CMD_P    = 3'd2;
    localparam logic [2:0] CMD_L    = 3'd3;
    localparam logic [2:0] CMD_T    = 3'd4;
    localparam logic [2:0] CMD_N    = 3'd5;
    localparam logic [2:0] CMD_O    = 3'd6;

    localparam int DIV_BITS = 18;
    localparam logic [DIV_BITS-1:0] DUR_DIVIDEND = 18'd240000;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

    function automatic logic [10:0] base_freq(input logic [3:0] semi);
        logic [10:0] f;
        begin
            case (semi)
                4'd0:    f = 11'd262;
                4'd1:    f = 11'd277;
                4'd2:    f = 11'd294;
                4'd3:    f = 11'd311;
                4'd4:    f = 11'd330;
                4'd5:    f = 11'd349;
                4'd6:    f = 11'd370;
                4'd7:    f = 11'd392;
                4'd8:    f = 11'd415;
                4'd9:    f = 11'd440;
                4'd10:   f = 11'd466;
                4'd11:   f = 11'd494;
                default: f = 11'd262;
            endcase
            return f;
        end
    endfunction

    function automatic logic [3:0] letter_semi(input logic [2:0] idx);
        logic [3:0] s;
        begin
            case (idx)
                3'd0:    s = 4'd9;
                3'd1:    s = 4'd11;
                3'd2:    s = 4'd0;
                3'd3:    s = 4'd2;
                3'd4:    s = 4'd4;
                3'd5:    s = 4'd5;
                3'd6:    s = 4'd7;
                default: s = 4'd0;
            endcase
            return s;
        end
    endfunction

    function automatic logic [10:0] pitch(input logic [3:0] semi, input logic [2:0] oct);
        logic [10:0] f;
        logic [2:0]  o;
        begin
            f = base_freq(semi);
            o = (oct > 3'd6) ? 3'd6 : oct;
            if (o < 3'd4)
                return f >> (3'd4 - o);
            return f << (o - 3'd4);
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/mml_char_if.sv -----
`default_nettype none
interface mml_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;
    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink (input valid, input char_code, input end_of_string, output ready);
endinterface
`default_nettype wire

// ----- src/mml_event_if.sv -----
`default_nettype none
interface mml_event_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [10:0] frequency;
    logic [13:0] duration;
    logic        last_of_run;
    modport source (output valid, output kind, output frequency, output duration,
                    output last_of_run, input ready);
    modport sink (input valid, input kind, input frequency, input duration,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- src/mml_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module mml_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [13:0]                    divisor,
    output logic                                done,
    output logic [mml_pkg::DIV_BITS-1:0]        quotient
);
    logic [mml_pkg::DIV_BITS-1:0] dvd_reg;
    logic [14:0]                  rem_reg;
    logic [4:0]                   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [14:0]                  trial;
    logic [15:0]                  diff;

    assign trial = {rem_reg[13:0], dvd_reg[mml_pkg::DIV_BITS-1]};
    assign diff  = {1'b0, trial} - {2'b00, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(mml_pkg::DIV_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= mml_pkg::DUR_DIVIDEND;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[15])
            begin
                rem_reg <= diff[14:0];
                dvd_reg <= {dvd_reg[mml_pkg::DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                dvd_reg <= {dvd_reg[mml_pkg::DIV_BITS-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;
endmodule
`default_nettype wire

// ----- src/mml_music_command_parser.sv -----
`default_nettype none
// Music macro string parser. One character is taken per transaction; the block
// then works on it alone and returns zero, one or two tone/rest events before
// taking the next character. The duration of each emitted event is set by the
// bit-serial duration divider (240000 / (tempo * length)), and the events are
// then offered on the output one after the other.
`include "mml_music_command_parser_macros.svh"
module mml_music_command_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    mml_char_if.sink           chars,
    mml_event_if.source        events
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PARSE = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_FIN   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_EOS   = 4'd6;
    localparam logic [3:0] S_RST   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]  state_reg;
    logic [3:0]  ret_reg;
    logic [7:0]  c_reg;
    logic        eos_reg;
    logic [2:0]  phase_reg;
    logic [2:0]  cmd_reg;
    logic [2:0]  octave_reg;
    logic [6:0]  deflen_reg;
    logic [7:0]  tempo_reg;
    logic [9:0]  acc_reg;
    logic [3:0]  semi_reg;
    logic        dotted_reg;
    logic        seen_reg;
    logic        ev_kind_reg;
    logic [10:0] ev_freq_reg;
    logic [6:0]  ev_len_reg;
    logic        ev_dot_reg;
    logic [13:0] prod_reg;
    logic [1:0]  cnt_reg;
    logic        idx_reg;
    logic        res_kind_reg [2];
    logic [10:0] res_freq_reg [2];
    logic [13:0] res_dur_reg  [2];

    mml_pkg::div_ctl_t          div_ctl;
    logic [mml_pkg::DIV_BITS-1:0] quot;
    logic [13:0]                q14;
    logic [13:0]                dur;
    logic                       dig;
    logic                       nz;
    logic [3:0]                 digit;
    logic [13:0]                acc_x10;
    logic [9:0]                 acc_add;
    logic [7:0]                 cu;
    logic                       len_ok;
    logic [6:0]                 nm;
    logic [2:0]                 n_oct;
    logic [6:0]                 n_semi;

    assign div_ctl.start = (state_reg == S_MUL);

    mml_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctl.start),
        .divisor  (prod_reg),
        .done     (div_ctl.done),
        .quotient (quot)
    );

    assign q14 = quot[13:0];
    assign dur = ev_dot_reg ? (q14 + {1'b0, q14[13:1]}) : q14;

    assign dig     = (c_reg >= 8'h30) && (c_reg <= 8'h39);
    assign nz      = (c_reg >= 8'h31) && (c_reg <= 8'h39);
    assign digit   = c_reg[3:0];
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {10'b0, digit};
    assign acc_add = (acc_x10 > 14'd1023) ? 10'd1023 : acc_x10[9:0];
    assign cu      = ((c_reg >= 8'h61) && (c_reg <= 8'h7A)) ? (c_reg - 8'd32) : c_reg;
    assign len_ok  = (acc_reg >= 10'd1) && (acc_reg <= 10'd64);
    assign nm      = acc_reg[6:0] - 7'd1;

    always_comb
    begin
        n_oct = 3'd0;
        for (int k = 1; k <= 6; k++)
        begin
            if (nm >= 7'(12 * k))
                n_oct = 3'(k);
        end
        n_semi = nm - 7'(n_oct * 4'd12);
    end

    assign chars.ready        = (state_reg == S_IDLE);
    assign events.valid       = (state_reg == S_OUT);
    assign events.kind        = res_kind_reg[idx_reg];
    assign events.frequency   = res_freq_reg[idx_reg];
    assign events.duration    = res_dur_reg[idx_reg];
    assign events.last_of_run = ({1'b0, idx_reg} == (cnt_reg - 2'd1));

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV && div_ctl.done && cnt_reg != 2'd2)
        begin
            res_kind_reg[cnt_reg[0]] <= ev_kind_reg;
            res_freq_reg[cnt_reg[0]] <= ev_freq_reg;
            res_dur_reg[cnt_reg[0]]  <= dur;
        end
        if (state_reg == S_MUL)
            prod_reg <= 14'(tempo_reg * ev_len_reg);
        if (state_reg == S_IDLE && chars.valid)
        begin
            c_reg   <= chars.char_code;
            eos_reg <= chars.end_of_string;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_EOS;
            phase_reg   <= mml_pkg::PH_IDLE;
            cmd_reg     <= mml_pkg::CMD_NONE;
            octave_reg  <= 3'd4;
            deflen_reg  <= 7'd4;
            tempo_reg   <= 8'd120;
            acc_reg     <= '0;
            semi_reg    <= '0;
            dotted_reg  <= 1'b0;
            seen_reg    <= 1'b0;
            cnt_reg     <= '0;
            idx_reg     <= 1'b0;
            ev_kind_reg <= 1'b0;
            ev_freq_reg <= '0;
            ev_len_reg  <= 7'd4;
            ev_dot_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (chars.valid)
                    begin
                        cnt_reg   <= '0;
                        idx_reg   <= 1'b0;
                        state_reg <= S_PARSE;
                    end
                end
                S_PARSE:
                begin
                    state_reg <= S_EOS;
                    ret_reg   <= S_START;
                    case (phase_reg)
                        mml_pkg::PH_NOTE_ACC, mml_pkg::PH_NOTE_LEN:
                        begin
                            if (phase_reg == mml_pkg::PH_NOTE_ACC &&
                                (c_reg == 8'h23 || c_reg == 8'h2B))
                            begin
                                semi_reg  <= (semi_reg >= 4'd11) ? 4'd0 : semi_reg + 4'd1;
                                phase_reg <= mml_pkg::PH_NOTE_LEN;
                            end
                            else if (phase_reg == mml_pkg::PH_NOTE_ACC && c_reg == 8'h2D)
                            begin
                                semi_reg  <= (semi_reg == 4'd0) ? 4'd11 : semi_reg - 4'd1;
                                phase_reg <= mml_pkg::PH_NOTE_LEN;
                            end
                            else if (nz)
                            begin
                                acc_reg   <= acc_add;
                                seen_reg  <= 1'b1;
                                phase_reg <= mml_pkg::PH_LEN_DIGITS;
                            end
                            else if (c_reg == 8'h2E)
                            begin
                                dotted_reg <= 1'b1;
                                ret_reg    <= S_EOS;
                                state_reg  <= S_FIN;
                            end
                            else
                                state_reg <= S_FIN;
                        end
                        mml_pkg::PH_LEN_DIGITS:
                        begin
                            if (dig)
                            begin
                                acc_reg  <= acc_add;
                                seen_reg <= 1'b1;
                            end
                            else if (c_reg == 8'h2E && cmd_reg == mml_pkg::CMD_NOTE)
                            begin
                                dotted_reg <= 1'b1;
                                ret_reg    <= S_EOS;
                                state_reg  <= S_FIN;
                            end
                            else
                                state_reg <= S_FIN;
                        end
                        mml_pkg::PH_P_START:
                        begin
                            if (nz)
                            begin
                                acc_reg   <= acc_add;
                                seen_reg  <= 1'b1;
                                phase_reg <= mml_pkg::PH_LEN_DIGITS;
                            end
                            else
                                state_reg <= S_FIN;
                        end
                        mml_pkg::PH_NUM:
                        begin
                            if (dig)
                            begin
                                acc_reg  <= acc_add;
                                seen_reg <= 1'b1;
                            end
                            else
                                state_reg <= S_FIN;
                        end
                        mml_pkg::PH_OCT:
                        begin
                            if (c_reg >= 8'h30 && c_reg <= 8'h36)
                            begin
                                octave_reg <= c_reg[2:0];
                                phase_reg  <= mml_pkg::PH_IDLE;
                                cmd_reg    <= mml_pkg::CMD_NONE;
                                acc_reg    <= '0;
                                seen_reg   <= 1'b0;
                                semi_reg   <= '0;
                                dotted_reg <= 1'b0;
                            end
                            else
                                state_reg <= S_FIN;
                        end
                        default:
                            state_reg <= S_START;
                    endcase
                end
                S_START:
                begin
                    state_reg <= S_EOS;
                    if (cu >= 8'h41 && cu <= 8'h47)
                    begin
                        cmd_reg   <= mml_pkg::CMD_NOTE;
                        semi_reg  <= mml_pkg::letter_semi(3'(cu - 8'h41));
                        phase_reg <= mml_pkg::PH_NOTE_ACC;
                    end
                    else if (cu == 8'h4F)
                    begin
                        cmd_reg   <= mml_pkg::CMD_O;
                        phase_reg <= mml_pkg::PH_OCT;
                    end
                    else if (cu == 8'h3E)
                    begin
                        if (octave_reg < 3'd6)
                            octave_reg <= octave_reg + 3'd1;
                    end
                    else if (cu == 8'h3C)
                    begin
                        if (octave_reg > 3'd0)
                            octave_reg <= octave_reg - 3'd1;
                    end
                    else if (cu == 8'h4C || cu == 8'h54 || cu == 8'h4E)
                    begin
                        cmd_reg   <= (cu == 8'h4C) ? mml_pkg::CMD_L :
                                     ((cu == 8'h54) ? mml_pkg::CMD_T : mml_pkg::CMD_N);
                        phase_reg <= mml_pkg::PH_NUM;
                    end
                    else if (cu == 8'h50)
                    begin
                        cmd_reg   <= mml_pkg::CMD_P;
                        phase_reg <= mml_pkg::PH_P_START;
                    end
                end
                S_FIN:
                begin
                    state_reg   <= ret_reg;
                    ev_dot_reg  <= 1'b0;
                    ev_len_reg  <= deflen_reg;
                    case (cmd_reg)
                        mml_pkg::CMD_NOTE:
                        begin
                            ev_kind_reg <= 1'b0;
                            ev_freq_reg <= mml_pkg::pitch(semi_reg, octave_reg);
                            ev_dot_reg  <= dotted_reg;
                            if (seen_reg && len_ok)
                                ev_len_reg <= acc_reg[6:0];
                            state_reg   <= S_MUL;
                        end
                        mml_pkg::CMD_P:
                        begin
                            ev_kind_reg <= 1'b1;
                            ev_freq_reg <= '0;
                            if (seen_reg && len_ok)
                                ev_len_reg <= acc_reg[6:0];
                            state_reg   <= S_MUL;
                        end
                        mml_pkg::CMD_L:
                        begin
                            if (len_ok)
                                deflen_reg <= acc_reg[6:0];
                        end
                        mml_pkg::CMD_T:
                        begin
                            if (acc_reg >= 10'd32 && acc_reg <= 10'd255)
                                tempo_reg <= acc_reg[7:0];
                        end
                        mml_pkg::CMD_N:
                        begin
                            if (acc_reg == 10'd0)
                            begin
                                ev_kind_reg <= 1'b1;
                                ev_freq_reg <= '0;
                                state_reg   <= S_MUL;
                            end
                            else if (acc_reg <= 10'd84)
                            begin
                                ev_kind_reg <= 1'b0;
                                ev_freq_reg <= mml_pkg::pitch(n_semi[3:0], n_oct);
                                state_reg   <= S_MUL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    phase_reg  <= mml_pkg::PH_IDLE;
                    cmd_reg    <= mml_pkg::CMD_NONE;
                    acc_reg    <= '0;
                    seen_reg   <= 1'b0;
                    semi_reg   <= '0;
                    dotted_reg <= 1'b0;
                end
                S_MUL:
                    state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_ctl.done)
                    begin
                        if (cnt_reg != 2'd2)
                            cnt_reg <= cnt_reg + 2'd1;
                        state_reg <= ret_reg;
                    end
                end
                S_EOS:
                begin
                    if (eos_reg)
                    begin
                        ret_reg   <= S_RST;
                        state_reg <= S_FIN;
                    end
                    else
                        state_reg <= (cnt_reg == 2'd0) ? S_IDLE : S_OUT;
                end
                S_RST:
                begin
                    octave_reg <= 3'd4;
                    deflen_reg <= 7'd4;
                    tempo_reg  <= 8'd120;
                    state_reg  <= (cnt_reg == 2'd0) ? S_IDLE : S_OUT;
                end
                S_OUT:
                begin
                    if (events.ready)
                    begin
                        if (events.last_of_run)
                            state_reg <= S_IDLE;
                        else
                            idx_reg <= 1'b1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `MML_ASSERT(a_cnt_max, cnt_reg != 2'd3)
    `MML_ASSERT(a_ready_excl, !(chars.ready && events.valid))
    `MML_ASSERT(a_done_in_div, div_ctl.done |-> state_reg == S_DIV)
    `MML_ASSERT_NEXT(a_mul_to_div, state_reg == S_MUL, state_reg == S_DIV)
    `MML_ASSERT(a_out_nonempty, events.valid |-> cnt_reg != 2'd0)
endmodule
`default_nettype wire
